// ===== hw/rtl/qeg_pkg.sv =====
// ----------------------------------------------------------------------------
// qeg_pkg
// shared widths, register indexes and handshake types of the quadrature
// encoder generator
// ----------------------------------------------------------------------------
package qeg_pkg;

   // fixed field widths
   localparam int PPR_REG_W   = 16;
   localparam int SCALE_W     = 32;
   localparam int TICK_W      = 20;
   localparam int SPEED_W     = 32;
   localparam int RAW_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int NS_W        = 30;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PPR   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK  = 2'd2;

   // reset values of the configuration registers
   localparam logic [PPR_REG_W-1:0] PPR_RESET   = 16'd100;
   localparam logic [SCALE_W-1:0]   SCALE_RESET = 32'd65536;
   localparam logic [TICK_W-1:0]    TICK_RESET  = 20'd50000;

   // input word function codes
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_SPEED = 1'b1;

   // arithmetic constants
   localparam logic [NS_W-1:0]    NS_PER_SEC = 30'd1000000000;
   localparam logic [SCALE_W-1:0] Q16_ONE    = 32'd65536;

   // status from the speed calculation unit
   typedef struct packed {
      logic busy;
      logic done;
   } qeg_calc_status_type;

endpackage

// ===== hw/rtl/qeg_speed_calc.sv =====
// ----------------------------------------------------------------------------
// qeg_speed_calc
// converts a signed speed into a phase increment: a few partial products,
// then a restoring divide of one quotient bit per cycle with saturation
// ----------------------------------------------------------------------------
module qeg_speed_calc
   import qeg_pkg::*;
#(
   parameter int ACCUM_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SPEED_W-1:0] speed,
   input  logic [SCALE_W-1:0]        scale,
   input  logic [PPR_REG_W-1:0]      ppr,
   input  logic [TICK_W-1:0]         tick_period,
   output qeg_calc_status_type       status,
   output logic [ACCUM_WIDTH-1:0]    increment
);

   localparam int FACT_W = PPR_REG_W + TICK_W;
   localparam int PT_LO_W = FACT_W / 2;
   localparam int PT_HI_W = FACT_W - PT_LO_W;
   localparam int PSUM_W = SPEED_W + FACT_W;
   localparam int QW = ACCUM_WIDTH - 1;
   // numerator is speed * ppr * 4 * period, shifted up by the quotient width
   localparam int NUM_W = PSUM_W + 2 + QW;
   localparam int DEN_W = SCALE_W + NS_W;
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST_ITER = CNT_W'(NUM_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_PT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic [SPEED_W-1:0]   smag_ff;
   logic [SCALE_W-1:0]   cmag_ff;
   logic                 neg_ff;
   logic [FACT_W-1:0]    pt_ff;
   logic [PSUM_W-1:0]    psum_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [NUM_W-1:0]     num_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [QW-1:0]        quo_ff;
   logic                 ovf_ff;
   logic [CNT_W-1:0]     cnt_ff;

   logic [SPEED_W-1:0]   speed_u;
   logic                 sneg;
   logic                 cneg;
   logic [SPEED_W-1:0]   smag_in;
   logic [SCALE_W-1:0]   cmag_in;
   logic [PSUM_W-1:0]    hi_prod;
   logic [PSUM_W-1:0]    psum_in;
   logic [DEN_W:0]       rem_shift;
   logic                 rem_ge;
   logic [DEN_W-1:0]     rem_in;
   logic [QW-1:0]        mag;
   logic [ACCUM_WIDTH-1:0] mag_ext;

   always_comb begin
      speed_u = SPEED_W'(speed);
      sneg    = speed_u[SPEED_W-1];
      cneg    = scale[SCALE_W-1];
      smag_in = sneg ? (~speed_u + 1'b1) : speed_u;
      // zero scale counts as 1.0
      if (scale == '0) begin
         cmag_in = Q16_ONE;
         cneg    = 1'b0;
      end else begin
         cmag_in = cneg ? (~scale + 1'b1) : scale;
      end
   end

   always_comb begin
      hi_prod = (PSUM_W'(smag_ff) * PSUM_W'(pt_ff[FACT_W-1:PT_LO_W])) << PT_LO_W;
      psum_in = psum_ff + hi_prod;
   end

   // one shared subtract and compare per quotient bit
   always_comb begin
      rem_shift = {rem_ff, num_ff[NUM_W-1]};
      rem_ge    = rem_shift >= {1'b0, den_ff};
      rem_in    = rem_ge ? DEN_W'(rem_shift - {1'b0, den_ff}) : DEN_W'(rem_shift);
   end

   always_comb begin
      mag       = ovf_ff ? {QW{1'b1}} : quo_ff;
      mag_ext   = {1'b0, mag};
      increment = neg_ff ? ACCUM_WIDTH'('0 - mag_ext) : mag_ext;
   end

   assign status.busy = (state_ff != ST_IDLE);
   assign status.done = (state_ff == ST_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  smag_ff  <= smag_in;
                  cmag_ff  <= cmag_in;
                  neg_ff   <= sneg ^ cneg;
                  state_ff <= ST_MUL_PT;
               end
            end
            ST_MUL_PT: begin
               pt_ff    <= FACT_W'(ppr) * FACT_W'(tick_period);
               den_ff   <= DEN_W'(cmag_ff) * DEN_W'(NS_PER_SEC);
               state_ff <= ST_MUL_LO;
            end
            ST_MUL_LO: begin
               psum_ff  <= PSUM_W'(smag_ff) * PSUM_W'(pt_ff[PT_LO_W-1:0]);
               state_ff <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               num_ff   <= {psum_in, 2'b00, {QW{1'b0}}};
               rem_ff   <= '0;
               quo_ff   <= '0;
               ovf_ff   <= 1'b0;
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               num_ff <= {num_ff[NUM_W-2:0], 1'b0};
               quo_ff <= QW'({quo_ff, rem_ge});
               // a bit shifted out of the quotient means saturation
               ovf_ff <= ovf_ff | quo_ff[QW-1];
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_ITER) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("remainder not below divisor");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == ST_IDLE))
      else $error("speed calculation started while busy");

   a_inc_saturated: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (increment != {1'b1, {QW{1'b0}}}))
      else $error("increment magnitude beyond one step per tick");
`endif

endmodule

// ===== hw/rtl/quadrature_encoder_generator_top.sv =====
// ----------------------------------------------------------------------------
// quadrature_encoder_generator_top
// simulated quadrature encoder with index pulse, driven by a phase
// accumulator whose increment is set from a commanded speed
// ----------------------------------------------------------------------------
//  channel  direction  handshake               word
//  req      in         req_valid / req_stall   func, speed_cmd
//  rsp      out        rsp_valid / rsp_stall   phase_a, phase_b, phase_z, raw_count
//  csr      in         csr_valid / csr_ready   index, write data
//
//  a tick word is one accumulate and at most one step of the encoder
//  a speed word passes the accepting idle state, the multiply states
//  ST_MUL_PT, ST_MUL_LO and ST_MUL_HI, the restoring divider in ST_DIV,
//  one quotient bit per step, and ST_DONE, which loads the increment
//  req_stall is high during a speed update and while a result is held
//  reset is synchronous; configuration returns to its reset values and
//  the accumulator, increment, encoder state and count clear to zero
// ----------------------------------------------------------------------------
module quadrature_encoder_generator_top
   import qeg_pkg::*;
#(
   parameter int ACCUM_WIDTH = 32,
   parameter int COUNT_WIDTH = 32,
   parameter int PPR_WIDTH   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic signed [SPEED_W-1:0]     req_speed_cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_phase_a,
   output logic                          rsp_phase_b,
   output logic                          rsp_phase_z,
   output logic signed [RAW_W-1:0]       rsp_raw_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int CMP_W = (PPR_WIDTH > PPR_REG_W) ? PPR_WIDTH : PPR_REG_W;

   logic [PPR_REG_W-1:0]   ppr_ff;
   logic [SCALE_W-1:0]     scale_ff;
   logic [TICK_W-1:0]      tick_ff;

   logic [ACCUM_WIDTH-1:0] accum_ff, accum_in;
   logic [ACCUM_WIDTH-1:0] inc_ff;
   logic [1:0]             quad_ff, quad_in;
   logic [PPR_WIDTH-1:0]   cyc_ff, cyc_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;

   logic                   rsp_valid_ff;
   logic                   rsp_phase_a_ff;
   logic                   rsp_phase_b_ff;
   logic                   rsp_phase_z_ff;
   logic [RAW_W-1:0]       rsp_raw_count_ff;

   qeg_calc_status_type    calc_status;
   logic [ACCUM_WIDTH-1:0] calc_inc;
   logic                   req_accept;
   logic                   tick_accept;
   logic                   speed_accept;
   logic                   top_old;
   logic                   top_new;
   logic [PPR_WIDTH-1:0]   cyc_up;

   assign req_stall    = calc_status.busy | (rsp_valid_ff & rsp_stall);
   assign req_accept   = req_valid & ~req_stall;
   assign tick_accept  = req_accept & (req_func == FUNC_TICK);
   assign speed_accept = req_accept & (req_func == FUNC_SPEED);
   assign csr_ready    = ~calc_status.busy;

   qeg_speed_calc #(
      .ACCUM_WIDTH(ACCUM_WIDTH)
   ) u_calc (
      .clock      (clock),
      .reset      (reset),
      .start      (speed_accept),
      .speed      (req_speed_cmd),
      .scale      (scale_ff),
      .ppr        (ppr_ff),
      .tick_period(tick_ff),
      .status     (calc_status),
      .increment  (calc_inc)
   );

   // one tick: accumulate, then step the encoder on a toggle of the top bit
   always_comb begin
      accum_in = accum_ff + inc_ff;
      top_old  = accum_ff[ACCUM_WIDTH-1];
      top_new  = accum_in[ACCUM_WIDTH-1];
      quad_in  = quad_ff;
      cyc_in   = cyc_ff;
      total_in = total_ff;
      cyc_up   = cyc_ff + 1'b1;
      if (top_old != top_new) begin
         if (inc_ff[ACCUM_WIDTH-1]) begin
            total_in = total_ff - 1'b1;
            if (quad_ff == 2'd0) begin
               quad_in = 2'd3;
               if (ppr_ff == '0) begin
                  cyc_in = '0;
               end else if (cyc_ff == '0) begin
                  cyc_in = PPR_WIDTH'(ppr_ff - 1'b1);
               end else begin
                  cyc_in = cyc_ff - 1'b1;
               end
            end else begin
               quad_in = quad_ff - 1'b1;
            end
         end else begin
            total_in = total_ff + 1'b1;
            if (quad_ff == 2'd3) begin
               quad_in = 2'd0;
               // wrap also when ppr was lowered below the position
               if ((ppr_ff == '0) || (CMP_W'(cyc_up) >= CMP_W'(ppr_ff))) begin
                  cyc_in = '0;
               end else begin
                  cyc_in = cyc_up;
               end
            end else begin
               quad_in = quad_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff       <= PPR_RESET;
         scale_ff     <= SCALE_RESET;
         tick_ff      <= TICK_RESET;
         accum_ff     <= '0;
         inc_ff       <= '0;
         quad_ff      <= '0;
         cyc_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PPR:   ppr_ff   <= csr_wdata[PPR_REG_W-1:0];
               CSR_SCALE: scale_ff <= csr_wdata[SCALE_W-1:0];
               CSR_TICK:  tick_ff  <= csr_wdata[TICK_W-1:0];
               default:   ;
            endcase
         end
         if (calc_status.done) begin
            inc_ff <= calc_inc;
         end
         if (tick_accept) begin
            accum_ff         <= accum_in;
            quad_ff          <= quad_in;
            cyc_ff           <= cyc_in;
            total_ff         <= total_in;
            rsp_valid_ff     <= 1'b1;
            rsp_phase_a_ff   <= (quad_in == 2'd0) || (quad_in == 2'd1);
            rsp_phase_b_ff   <= (quad_in == 2'd1) || (quad_in == 2'd2);
            rsp_phase_z_ff   <= (quad_in == 2'd0) && (cyc_in == '0);
            rsp_raw_count_ff <= RAW_W'(total_in);
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phase_a   = rsp_phase_a_ff;
   assign rsp_phase_b   = rsp_phase_b_ff;
   assign rsp_phase_z   = rsp_phase_z_ff;
   assign rsp_raw_count = rsp_raw_count_ff;

`ifndef SYNTHESIS
   a_stall_while_busy: assert property (@(posedge clock) disable iff (reset)
      calc_status.busy |-> req_stall)
      else $error("word accepted during speed update");

   a_speed_starts_calc: assert property (@(posedge clock) disable iff (reset)
      speed_accept |=> calc_status.busy)
      else $error("speed word did not start the calculation");

   a_quad_single_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (quad_ff == $past(quad_ff)) ||
                        (quad_ff == 2'($past(quad_ff) + 2'd1)) ||
                        (quad_ff == 2'($past(quad_ff) - 2'd1)))
      else $error("encoder moved more than one state");

   a_result_from_tick: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(tick_accept))
      else $error("result word without a tick");
`endif

endmodule

// ===== tb/sv/tb_quadrature_encoder_generator_top.sv =====
// ----------------------------------------------------------------------------
// tb_quadrature_encoder_generator_top
// self-checking bench for the quadrature encoder generator: a queued driver
// feeds tick and speed words with random gaps, a monitor predicts every
// tick result from its own copy of the encoder and compares it field by
// field, and the registers are rewritten between phases of random traffic
// ----------------------------------------------------------------------------
module tb_quadrature_encoder_generator_top;
   import qeg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // no acceptance on any channel for this long means the block is stuck
   localparam int WATCHDOG_LIMIT = 2000;
   // a speed word keeps the divider busy and yields no result
   localparam int SETTLE_CYCLES  = 150;
   localparam int MAX_PRINTED    = 50;
   localparam logic [31:0] STEP_CAP = 32'h7fff_ffff;

   typedef struct packed {
      logic                      func;
      logic signed [SPEED_W-1:0] speed;
   } cmd_word_type;

   typedef struct packed {
      logic                    a;
      logic                    b;
      logic                    z;
      logic signed [RAW_W-1:0] count;
   } encoder_word_type;

   logic clock;
   logic reset = 1'b1;

   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic                      req_func      = FUNC_TICK;
   logic signed [SPEED_W-1:0] req_speed_cmd = '0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   logic                      rsp_phase_a;
   logic                      rsp_phase_b;
   logic                      rsp_phase_z;
   logic signed [RAW_W-1:0]   rsp_raw_count;
   logic                      csr_valid     = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index     = CSR_PPR;
   logic [CSR_DATA_W-1:0]     csr_wdata     = '0;

   quadrature_encoder_generator_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_speed_cmd (req_speed_cmd),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_phase_a   (rsp_phase_a),
      .rsp_phase_b   (rsp_phase_b),
      .rsp_phase_z   (rsp_phase_z),
      .rsp_raw_count (rsp_raw_count),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // predicted encoder: configuration and state
   logic [PPR_REG_W-1:0] cfg_ppr;
   logic [SCALE_W-1:0]   cfg_scale;
   logic [TICK_W-1:0]    cfg_tick;
   logic [31:0]          enc_accum;
   logic [31:0]          enc_step;
   logic [1:0]           enc_quad;
   logic [15:0]          enc_cycle;
   logic [31:0]          enc_total;

   cmd_word_type     cmd_pending[$];
   encoder_word_type encoder_expected[$];

   int  words_issued   = 0;
   int  words_accepted = 0;
   int  mismatch_count = 0;
   int  req_idle_max   = 0;
   int  rsp_idle_max   = 0;
   int  phase_no       = 0;
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void encoder_reset();
      cfg_ppr   = PPR_RESET;
      cfg_scale = SCALE_RESET;
      cfg_tick  = TICK_RESET;
      enc_accum = '0;
      enc_step  = '0;
      enc_quad  = '0;
      enc_cycle = '0;
      enc_total = '0;
   endfunction

   function automatic void encoder_config(logic [CSR_INDEX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PPR: begin
            cfg_ppr = data[PPR_REG_W-1:0];
         end
         CSR_SCALE: begin
            cfg_scale = data[SCALE_W-1:0];
         end
         CSR_TICK: begin
            cfg_tick = data[TICK_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   // step increment = speed/scale * ppr * 4 * period_ns * 1e-9 * 2^31, toward zero
   function automatic void encoder_set_speed(logic signed [SPEED_W-1:0] speed);
      logic         s_neg;
      logic         c_neg;
      logic [32:0]  s_mag;
      logic [32:0]  c_mag;
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] quo;
      logic [31:0]  mag;
      s_neg = speed[SPEED_W-1];
      c_neg = cfg_scale[SCALE_W-1];
      s_mag = s_neg ? 33'h1_0000_0000 - {1'b0, speed} : {1'b0, speed};
      c_mag = c_neg ? 33'h1_0000_0000 - {1'b0, cfg_scale} : {1'b0, cfg_scale};
      if (cfg_scale == '0) begin
         c_neg = 1'b0;
         c_mag = {1'b0, Q16_ONE};
      end
      num = 128'(s_mag) * 128'(cfg_ppr) * 128'(cfg_tick) * 128'd4;
      num = num << 31;
      den = 128'(c_mag) * 128'(NS_PER_SEC);
      quo = num / den;
      mag = (quo > 128'(STEP_CAP)) ? STEP_CAP : quo[31:0];
      enc_step = (s_neg != c_neg) ? 32'd0 - mag : mag;
   endfunction

   function automatic encoder_word_type encoder_tick();
      encoder_word_type w;
      logic             top_was;
      top_was   = enc_accum[31];
      enc_accum = enc_accum + enc_step;
      if (top_was != enc_accum[31]) begin
         if (enc_step[31]) begin
            enc_total = enc_total - 32'd1;
            if (enc_quad == 2'd0) begin
               enc_quad = 2'd3;
               if (cfg_ppr == '0)
                  enc_cycle = '0;
               else if (enc_cycle == '0)
                  enc_cycle = cfg_ppr - 16'd1;
               else
                  enc_cycle = enc_cycle - 16'd1;
            end else begin
               enc_quad = enc_quad - 2'd1;
            end
         end else begin
            enc_total = enc_total + 32'd1;
            if (enc_quad == 2'd3) begin
               enc_quad  = 2'd0;
               enc_cycle = enc_cycle + 16'd1;
               // a lowered ppr can leave the position beyond the new range
               if (cfg_ppr == '0 || enc_cycle >= cfg_ppr)
                  enc_cycle = '0;
            end else begin
               enc_quad = enc_quad + 2'd1;
            end
         end
      end
      w.a     = (enc_quad == 2'd0 || enc_quad == 2'd1);
      w.b     = (enc_quad == 2'd1 || enc_quad == 2'd2);
      w.z     = (enc_quad == 2'd0 && enc_cycle == '0);
      w.count = enc_total;
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("%0t ns: %s mismatch, got %h expected %h", $realtime, what, got, want);
   endtask

   // monitor and predictor
   always @(posedge clock) begin
      encoder_word_type want;
      if (reset) begin
         encoder_reset();
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;
         if (csr_valid && csr_ready)
            encoder_config(csr_index, csr_wdata);
         if (req_valid && !req_stall) begin
            words_accepted++;
            if (req_func == FUNC_SPEED)
               encoder_set_speed(req_speed_cmd);
            else
               encoder_expected.push_back(encoder_tick());
         end
         if (rsp_valid && !rsp_stall) begin
            if (encoder_expected.size() == 0) begin
               report_mismatch("unexpected result word", rsp_raw_count, '0);
            end else begin
               want = encoder_expected.pop_front();
               if (rsp_phase_a !== want.a)
                  report_mismatch("phase_a", 32'(rsp_phase_a), 32'(want.a));
               if (rsp_phase_b !== want.b)
                  report_mismatch("phase_b", 32'(rsp_phase_b), 32'(want.b));
               if (rsp_phase_z !== want.z)
                  report_mismatch("phase_z", 32'(rsp_phase_z), 32'(want.z));
               if (rsp_raw_count !== want.count)
                  report_mismatch("raw_count", rsp_raw_count, want.count);
            end
         end
      end
   end

   // command driver
   int req_gap = 0;
   always @(negedge clock) begin
      cmd_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // stalled word holds
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap--;
      end else if (cmd_pending.size() != 0) begin
         w = cmd_pending.pop_front();
         req_valid     <= 1'b1;
         req_func      <= w.func;
         req_speed_cmd <= w.speed;
         req_gap = $urandom_range(0, req_idle_max);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result back-pressure, drawn once per accepted result word
   int rsp_hold = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken)
            rsp_hold = $urandom_range(0, rsp_idle_max);
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("** quadrature_encoder_generator_top: FAILED **");
            $finish;
         end
      end
   end

   function automatic void push_word(logic func, logic signed [SPEED_W-1:0] speed);
      cmd_word_type w;
      w.func  = func;
      w.speed = speed;
      cmd_pending.push_back(w);
      words_issued++;
   endfunction

   // random magnitude across the whole range, both signs
   function automatic logic signed [31:0] random_signed();
      logic signed [31:0] v;
      v = $urandom;
      return v >>> $urandom_range(0, 31);
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // all words in, all results out, then let a pending divide finish
   task automatic settle();
      while (words_issued != words_accepted || encoder_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input logic [PPR_REG_W-1:0] ppr,
                            input logic [SCALE_W-1:0] scale,
                            input logic [TICK_W-1:0] tick,
                            input logic signed [SPEED_W-1:0] lead_speed,
                            input int words);
      settle();
      phase_no++;
      req_idle_max = (phase_no % 3 == 0) ? 0 : 10;
      rsp_idle_max = (phase_no % 3 == 1) ? 0 : 10;
      csr_write(CSR_PPR, 32'(ppr));
      csr_write(CSR_SCALE, scale);
      csr_write(CSR_TICK, 32'(tick));
      push_word(FUNC_SPEED, lead_speed);
      for (int i = 0; i < words; i++)
         push_word(($urandom_range(0, 99) < 15) ? FUNC_SPEED : FUNC_TICK,
                   random_signed());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration: zero increment, both saturations, tiny steps
      push_word(FUNC_TICK, 32'sh0000_0000);
      push_word(FUNC_TICK, 32'shffff_ffff);
      push_word(FUNC_SPEED, 32'sh7fff_ffff);
      repeat (6) push_word(FUNC_TICK, 32'sh0000_0000);
      push_word(FUNC_SPEED, 32'sh8000_0000);
      repeat (6) push_word(FUNC_TICK, 32'sh5555_aaaa);
      push_word(FUNC_SPEED, 32'sh0000_0000);
      push_word(FUNC_TICK, 32'sh0000_0000);
      push_word(FUNC_SPEED, 32'sh0000_0001);
      push_word(FUNC_TICK, 32'sh0000_0000);
      push_word(FUNC_SPEED, 32'shffff_ffff);
      push_word(FUNC_TICK, 32'sh0000_0000);
      push_word(FUNC_SPEED, 32'sh0005_0000);
      push_word(FUNC_TICK, 32'sh0000_0000);
      for (int i = 0; i < 250; i++)
         push_word(($urandom_range(0, 99) < 15) ? FUNC_SPEED : FUNC_TICK,
                   random_signed());

      // widest settings first so the position climbs, then a small ppr
      run_phase(16'hffff, 32'h7fff_ffff, 20'hfffff, 32'sh7fff_ffff, 250);
      run_phase(16'd5, 32'h8000_0000, 20'd1000000, 32'sh8000_0000, 250);
      run_phase(16'd0, 32'h0000_0000, 20'd50000, 32'sh0001_0000, 200);
      run_phase(16'd1, 32'hffff_0000, 20'd1, 32'sh7fff_ffff, 200);
      run_phase(16'd100, 32'h0000_0000, 20'd0, 32'sh8000_0000, 150);
      for (int p = 0; p < 4; p++)
         run_phase(16'($urandom_range(1, 16)), random_signed(),
                   20'($urandom_range(1, 1000000)), random_signed(), 150);

      settle();
      if (mismatch_count == 0)
         $display("** quadrature_encoder_generator_top: PASSED **");
      else
         $display("** quadrature_encoder_generator_top: FAILED **");
      $finish;
   end

endmodule
